/* sv/sorted_list_engine_core_macros.svh */
// assertion macros used by the sorted list engine rtl
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sle assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sle assertion failed");

`endif

/* sv/sle_pkg.sv */
// types and constants of the sorted list engine
`default_nettype none

package sle_pkg;

  // default list capacity, fixed value width and position and count widths
  localparam int unsigned Depth  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_DUMP   = 2'd3
  } sle_mode_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } sle_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } sle_state_e;

  // per-cycle action broadcast along the cell chain
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_ROTATE = 3'd4
  } sle_op_e;

  typedef struct packed {
    sle_mode_e                mode;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } sle_req_t;

  typedef struct packed {
    sle_status_e              status;
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        entry_count;
    logic                     last;
  } sle_res_t;

  typedef struct packed {
    sle_op_e                  op;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } sle_cmd_t;

endpackage

`default_nettype wire

/* sv/sorted_list_engine_core.sv */
// top level of the sorted list engine: control, count and the cell chain
//
// Requests enter on req_i (mode, value, position) and are taken at a rising
// edge with start high and busy low. Results leave on res_o and are valid
// for exactly one cycle while res_strobe_o is high; the receiver cannot
// hold them off, and last marks the final result of a request.
// Append, sorted insert and delete finish in the cycle they are taken:
// every slot of the cell chain decides locally and shifts at the edge that
// takes the request, and the single registered result shows in the next
// cycle. busy stays low, so such requests may follow one per cycle.
// A dump of N entries raises busy while it streams one entry per cycle,
// each registered from the head slot in the dump state; the chain rotates
// one slot per cycle past the head tap and is back in order when busy falls.
// An empty dump, a full list or a bad delete position gives one result
// with the matching status and leaves the list untouched.
// Reset empties the list and drops busy and the strobe; slot contents are
// not cleared and are only read after being written.
`default_nettype none
`include "sorted_list_engine_core_macros.svh"

module sorted_list_engine_core #(
  parameter int unsigned DEPTH = sle_pkg::Depth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire sle_pkg::sle_req_t req_i,
  output logic                   res_strobe_o,
  output sle_pkg::sle_res_t      res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sle_pkg::sle_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                strobe_q, strobe_d;
  sle_pkg::sle_res_t   res_q, res_d;
  sle_pkg::sle_cmd_t   cmd;
  logic                accept, list_full, bad_pos, dump_last;

  logic signed [sle_pkg::ValueW-1:0] cell_val [DEPTH];
  logic                              cell_found [DEPTH];

  assign accept    = start && !busy;
  assign list_full = cnt_q == CntW'(DEPTH);
  assign bad_pos   = (req_i.position == '0) || (32'(req_i.position) > 32'(cnt_q));
  assign dump_last = idx_q == CntW'(cnt_q - 1'b1);

  // control state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sle_pkg::ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // request decode, chain action and result
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    strobe_d     = 1'b0;
    res_d        = res_q;
    cmd.op       = sle_pkg::OP_NONE;
    cmd.value    = req_i.value;
    cmd.position = req_i.position;
    case (state_q)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          strobe_d          = 1'b1;
          res_d.status      = sle_pkg::STAT_OK;
          res_d.entry_value = '0;
          res_d.last        = 1'b1;
          case (req_i.mode)
            sle_pkg::MODE_APPEND, sle_pkg::MODE_INSERT: begin
              if (list_full) begin
                res_d.status = sle_pkg::STAT_FULL;
              end else begin
                cmd.op = (req_i.mode == sle_pkg::MODE_APPEND) ?
                         sle_pkg::OP_APPEND : sle_pkg::OP_INSERT;
                cnt_d  = CntW'(cnt_q + 1'b1);
              end
            end
            sle_pkg::MODE_DELETE: begin
              if (bad_pos) begin
                res_d.status = sle_pkg::STAT_BADPOS;
              end else begin
                cmd.op = sle_pkg::OP_DELETE;
                cnt_d  = CntW'(cnt_q - 1'b1);
              end
            end
            sle_pkg::MODE_DUMP: begin
              if (cnt_q == '0) begin
                res_d.status = sle_pkg::STAT_EMPTY;
              end else begin
                strobe_d = 1'b0;
                state_d  = sle_pkg::ST_DUMP;
                idx_d    = '0;
              end
            end
            default: res_d.status = sle_pkg::STAT_OK;
          endcase
          res_d.entry_count = sle_pkg::CountW'(cnt_d);
        end
      end
      sle_pkg::ST_DUMP: begin
        // stream the head slot and rotate the chain by one
        strobe_d          = 1'b1;
        res_d.status      = sle_pkg::STAT_OK;
        res_d.entry_value = cell_val[0];
        res_d.entry_count = sle_pkg::CountW'(cnt_q);
        res_d.last        = dump_last;
        cmd.op            = sle_pkg::OP_ROTATE;
        idx_d             = CntW'(idx_q + 1'b1);
        if (dump_last) state_d = sle_pkg::ST_IDLE;
      end
      default: state_d = sle_pkg::ST_IDLE;
    endcase
  end

  // chain of list slots
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sle_pkg::ValueW-1:0] left_val, right_val;
    logic                              found_in;

    if (i == 0) begin : g_first
      assign left_val = cell_val[i];
      assign found_in = 1'b0;
    end else begin : g_inner
      assign left_val = cell_val[i-1];
      assign found_in = cell_found[i-1];
    end

    if (i == DEPTH - 1) begin : g_lastslot
      assign right_val = cell_val[i];
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    sle_cell #(
      .IDX (i),
      .CntW(CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .count_i(cnt_q),
      .left_i (left_val),
      .right_i(right_val),
      .head_i (cell_val[0]),
      .found_i(found_in),
      .found_o(cell_found[i]),
      .value_o(cell_val[i])
    );
  end

  assign busy         = state_q == sle_pkg::ST_DUMP;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // checks
  `SLE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, 32'(cnt_q) <= 32'(DEPTH))
  `SLE_ASSERT_NEXT(a_single_result, clk_i, rst_ni,
    accept && req_i.mode != sle_pkg::MODE_DUMP, res_strobe_o && res_o.last)
  `SLE_ASSERT_NEXT(a_dump_streams, clk_i, rst_ni, busy, res_strobe_o)
  `SLE_ASSERT_NEXT(a_append_grows, clk_i, rst_ni,
    accept && req_i.mode == sle_pkg::MODE_APPEND && !list_full,
    cnt_q == CntW'($past(cnt_q) + 1'b1))

endmodule

`default_nettype wire

/* sv/sle_cell.sv */
// one list slot of the cell chain: holds an entry and shifts with its neighbors
`default_nettype none

module sle_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CntW = 5
) (
  input  wire logic                             clk_i,
  input  wire sle_pkg::sle_cmd_t                cmd_i,
  input  wire logic [CntW-1:0]                  count_i,
  input  wire logic signed [sle_pkg::ValueW-1:0] left_i,
  input  wire logic signed [sle_pkg::ValueW-1:0] right_i,
  input  wire logic signed [sle_pkg::ValueW-1:0] head_i,
  input  wire logic                             found_i,
  output logic                                  found_o,
  output logic signed [sle_pkg::ValueW-1:0]     value_o
);

  logic signed [sle_pkg::ValueW-1:0] value_q, value_d;
  logic occupied, stop_here, at_tail, at_end;

  // position of this slot relative to the fill level
  assign occupied  = 32'(IDX) < 32'(count_i);
  assign at_tail   = 32'(IDX) == 32'(count_i);
  assign at_end    = 32'(IDX + 1) == 32'(count_i);

  // first held entry not below the new value stops the insert search
  assign stop_here = occupied && !(value_q < cmd_i.value);
  assign found_o   = found_i || stop_here;

  // slot update for the broadcast action
  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      sle_pkg::OP_APPEND: begin
        if (at_tail) value_d = cmd_i.value;
      end
      sle_pkg::OP_INSERT: begin
        if (found_i) value_d = left_i;
        else if (stop_here || at_tail) value_d = cmd_i.value;
      end
      sle_pkg::OP_DELETE: begin
        if (32'(IDX + 1) >= 32'(cmd_i.position)) value_d = right_i;
      end
      sle_pkg::OP_ROTATE: begin
        if (at_end) value_d = head_i;
        else if (32'(IDX + 1) < 32'(count_i)) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

/* tb/sorted_list_engine_core_tb.sv */
// self-checking testbench for the sorted list engine core
`default_nettype none

module sorted_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int unsigned StallLimit  = 500;
  localparam int unsigned RandomItems = 220;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned NumRows     = 19;

  // one line of the directed sequence; fixed_* holds the answer where it is obvious
  typedef struct {
    sle_mode_e   mode;
    logic [31:0] value;
    logic [4:0]  position;
    int unsigned reps;
    bit          fixed;
    sle_status_e fixed_status;
    logic [4:0]  fixed_count;
  } list_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  sle_req_t    req;
  logic        res_strobe;
  sle_res_t    res;

  // shadow copy of the list, kept in step with accepted requests
  logic signed [ValueW-1:0] shadow_list [Depth];
  int unsigned              shadow_count;
  sle_res_t                 replies_due [$];

  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned burst_left;

  list_row_t directed_rows [NumRows] = '{
    '{MODE_DUMP,   32'h0000_0000, 5'd0,  1, 1'b1, STAT_EMPTY,  5'd0},
    '{MODE_DELETE, 32'h0000_0000, 5'd1,  1, 1'b1, STAT_BADPOS, 5'd0},
    '{MODE_APPEND, 32'h7fff_ffff, 5'd0,  1, 1'b1, STAT_OK,     5'd1},
    '{MODE_INSERT, 32'h8000_0000, 5'd0,  1, 1'b1, STAT_OK,     5'd2},
    '{MODE_INSERT, 32'hffff_ffff, 5'd16, 1, 1'b1, STAT_OK,     5'd3},
    '{MODE_INSERT, 32'h0000_0000, 5'd0,  1, 1'b1, STAT_OK,     5'd4},
    '{MODE_INSERT, 32'h0000_0000, 5'd0,  1, 1'b1, STAT_OK,     5'd5},
    '{MODE_APPEND, 32'hffff_fffb, 5'd0,  1, 1'b1, STAT_OK,     5'd6},
    '{MODE_DUMP,   32'h0000_0000, 5'd0,  1, 1'b0, STAT_OK,     5'd0},
    '{MODE_DELETE, 32'h0000_0000, 5'd0,  1, 1'b1, STAT_BADPOS, 5'd6},
    '{MODE_DELETE, 32'h0000_0000, 5'd7,  1, 1'b1, STAT_BADPOS, 5'd6},
    '{MODE_DELETE, 32'h0000_0000, 5'd6,  1, 1'b1, STAT_OK,     5'd5},
    '{MODE_INSERT, 32'h1234_5678, 5'd0,  5, 1'b0, STAT_OK,     5'd0},
    '{MODE_APPEND, 32'ha5a5_a5a5, 5'd0,  6, 1'b0, STAT_OK,     5'd0},
    '{MODE_APPEND, 32'h0000_0001, 5'd0,  1, 1'b1, STAT_FULL,   5'd16},
    '{MODE_INSERT, 32'h8000_0000, 5'd0,  1, 1'b1, STAT_FULL,   5'd16},
    '{MODE_DUMP,   32'h0000_0000, 5'd0,  1, 1'b0, STAT_OK,     5'd0},
    '{MODE_DELETE, 32'h0000_0000, 5'd16, 1, 1'b1, STAT_OK,     5'd15},
    '{MODE_DELETE, 32'h0000_0000, 5'd16, 1, 1'b1, STAT_BADPOS, 5'd15}
  };

  sorted_list_engine_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req),
    .res_strobe_o (res_strobe),
    .res_o        (res)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // push one reply per result the list operation gives and update the shadow list
  function automatic void apply_list_op(input sle_req_t r);
    int unsigned slot;
    int unsigned i;
    sle_res_t    reply;
    reply = '{status: STAT_OK, entry_value: '0, entry_count: '0, last: 1'b1};
    case (r.mode)
      MODE_APPEND, MODE_INSERT: begin
        if (shadow_count >= Depth) begin
          reply.status = STAT_FULL;
        end else begin
          slot = shadow_count;
          if (r.mode == MODE_INSERT) begin
            // goes after smaller entries and before equal ones
            slot = 0;
            while (slot < shadow_count && shadow_list[slot] < r.value) slot++;
            for (i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[slot] = r.value;
          shadow_count++;
        end
        reply.entry_count = CountW'(shadow_count);
        replies_due.push_back(reply);
      end
      MODE_DELETE: begin
        if (r.position == 0 || r.position > shadow_count) begin
          reply.status = STAT_BADPOS;
        end else begin
          for (i = r.position - 1; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
        reply.entry_count = CountW'(shadow_count);
        replies_due.push_back(reply);
      end
      default: begin
        reply.entry_count = CountW'(shadow_count);
        if (shadow_count == 0) begin
          reply.status = STAT_EMPTY;
          replies_due.push_back(reply);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            reply.entry_value = shadow_list[i];
            reply.last        = (i + 1 == shadow_count);
            replies_due.push_back(reply);
          end
        end
      end
    endcase
  endfunction

  // drive one request, wait for it to be taken, then predict and pace the sender
  task automatic send_request(input sle_req_t r, input bit fixed, input sle_status_e st,
                              input logic [4:0] cnt);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    apply_list_op(r);
    // an obvious answer replaces the predicted one
    if (fixed) begin
      replies_due[replies_due.size()-1] =
        '{status: st, entry_value: '0, entry_count: cnt, last: 1'b1};
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // some bursts run long so back-to-back requests get exercised
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: pick_value = 32'($signed($urandom_range(0, 8)) - 4);
      3:       pick_value = 32'h8000_0000;
      4:       pick_value = 32'h7fff_ffff;
      default: pick_value = $urandom;
    endcase
  endfunction

  // compare each strobed result with the oldest outstanding reply
  task automatic check_reply(input sle_res_t got);
    sle_res_t want;
    if (replies_due.size() == 0) begin
      $error("result with nothing outstanding: status %0d value %0d count %0d last %0b",
             got.status, got.entry_value, got.entry_count, got.last);
      error_count++;
    end else begin
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.entry_value !== want.entry_value) begin
        $error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
        error_count++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        error_count++;
      end
    end
  endtask

  // result monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_strobe) check_reply(res);
      if (res_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus: directed rows, then random requests in growing and shrinking phases
  initial begin
    sle_req_t    r;
    bit          grow;
    int unsigned w;
    int unsigned k;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req          = '0;
    shadow_count = 0;
    error_count  = 0;
    quiet_cycles = 0;
    burst_left   = 4;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      for (k = 0; k < directed_rows[n].reps; k++) begin
        r.mode     = directed_rows[n].mode;
        r.value    = directed_rows[n].value;
        r.position = directed_rows[n].position;
        send_request(r, directed_rows[n].fixed, directed_rows[n].fixed_status,
                     directed_rows[n].fixed_count);
      end
    end

    for (int unsigned n = 0; n < RandomItems; n++) begin
      grow = ((n / 30) % 2) == 0;
      w    = $urandom_range(0, 99);
      if (grow) begin
        r.mode = (w < 30) ? MODE_APPEND : (w < 65) ? MODE_INSERT :
                 (w < 80) ? MODE_DELETE : MODE_DUMP;
      end else begin
        r.mode = (w < 10) ? MODE_APPEND : (w < 25) ? MODE_INSERT :
                 (w < 80) ? MODE_DELETE : MODE_DUMP;
      end
      r.value = pick_value();
      // mostly valid delete positions, the rest anywhere in range
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        r.position = PosW'($urandom_range(1, shadow_count));
      else
        r.position = PosW'($urandom_range(0, 16));
      send_request(r, 1'b0, STAT_OK, 5'd0);
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

/* sorted_list_engine_core.f */
+incdir+sv
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sorted_list_engine_core.sv
tb/sorted_list_engine_core_tb.sv
